// ===== rtl/radix_digit_emitter_macros.svh =====
// ----------------------------------------------------------------------------
// radix_digit_emitter_macros
// Assertion macros shared by the checker of the digit emitter.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_MACROS_SVH
`define RADIX_DIGIT_EMITTER_MACROS_SVH

// same-cycle implication
`define RDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants, types and the digit encoding of the digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

   localparam int VALUE_BITS_DEF = 63;
   localparam int NUMBER_W       = 63;
   localparam int CHAR_W         = 7;
   localparam int MODE_W         = 2;

   localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 7'd65;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 7'd97;
   localparam logic [3:0]        DIGIT_TEN     = 4'd10;

   typedef struct packed {
      logic load;
      logic shift_bit;
      logic skip;
      logic emit;
   } rde_cmd_type;

   typedef struct packed {
      logic hex;
      logic bits_done;
      logic top_zero;
      logic one_left;
      logic out_free;
   } rde_sts_type;

   // decimal digits of the largest value of the given bit width
   function automatic int dec_digits(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_code(input logic [3:0] d, input logic upper);
      logic [3:0] off;
      off = d - DIGIT_TEN;
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + {3'b000, d};
      end else if (upper) begin
         return CHAR_UPPER_A + {3'b000, off};
      end else begin
         return CHAR_LOWER_A + {3'b000, off};
      end
   endfunction

endpackage

// ===== rtl/radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts one unsigned integer per request into a stream of ASCII digits.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one integer per request (valid/ready); low VALUE_BITS bits used.
//   rsp_*  : one ASCII digit per response, most significant first, no leading
//            zeros; rsp_last_digit marks the final digit. Zero gives "0".
//   csr_*  : radix mode (0 decimal, 1 lowercase hex, 2 or 3 uppercase hex),
//            written when csr_write_enable is high; change it only when idle.
// Digit slots (D = digits emitted, Z = leading zero positions dropped):
//   hex     : Z + D = ceil(VALUE_BITS/4); the bit converter is bypassed.
//   decimal : Z + D = 19 digit slots at 63 bits, filled by the shift-add-3
//             converter, which takes in one bit of the value per step.
//   One digit leaves per cycle while rsp_ready is high; req_ready rises again
//   once the last digit sits in the output register.
// Reset clears the mode to decimal and drops any request in flight.
// A stalled receiver holds the current digit and pauses the digit shifter.
// ----------------------------------------------------------------------------
module radix_digit_emitter
   import rde_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [MODE_W-1:0]   csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [NUMBER_W-1:0] req_number_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAR_W-1:0]   rsp_digit_char,
   output logic                rsp_last_digit
);

   rde_cmd_type cmd;
   rde_sts_type sts;

   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rde_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// ===== rtl/rde_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer: accept, convert, drop leading zeros, emit digits.
// ----------------------------------------------------------------------------
module rde_ctrl
   import rde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rde_sts_type sts,
   output rde_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (sts.hex || sts.bits_done) begin
               state_in = ST_SKIP;
            end else begin
               cmd.shift_bit = 1'b1;
            end
         end
         ST_SKIP: begin
            if (sts.top_zero && !sts.one_left) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.one_left) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rde_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_datapath
// Mode register, shift-add-3 BCD converter, digit shifter and output stage.
// ----------------------------------------------------------------------------
module rde_datapath
   import rde_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [MODE_W-1:0]   csr_write_data,
   input  logic [NUMBER_W-1:0] req_number_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAR_W-1:0]   rsp_digit_char,
   output logic                rsp_last_digit,
   input  rde_cmd_type         cmd,
   output rde_sts_type         sts
);

   localparam int DEC_DIGITS = dec_digits(VALUE_BITS);
   localparam int DIGW       = 4 * DEC_DIGITS;
   localparam int NIB        = (VALUE_BITS + 3) / 4;
   localparam int HEX_SHIFT  = DIGW - 4 * NIB;
   localparam int BCW        = $clog2(VALUE_BITS + 1);
   localparam int DCW        = $clog2(DEC_DIGITS + 1);

   logic [MODE_W-1:0]     mode_ff;
   logic [MODE_W-1:0]     mode_in;
   logic                  hex_ff;
   logic                  upper_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] val_in;
   logic [DIGW-1:0]       dig_ff;
   logic [DIGW-1:0]       dig_in;
   logic [DIGW-1:0]       adj;
   logic [DIGW-1:0]       hex_ext;
   logic [BCW-1:0]        bit_cnt_ff;
   logic [BCW-1:0]        bit_cnt_in;
   logic [DCW-1:0]        dcnt_ff;
   logic [DCW-1:0]        dcnt_in;
   logic                  valid_ff;
   logic                  valid_in;
   logic [CHAR_W-1:0]     char_ff;
   logic                  last_ff;
   logic [3:0]            top_nib;

   assign mode_in = csr_write_enable ? csr_write_data : mode_ff;
   assign top_nib = dig_ff[DIGW-1 -: 4];
   assign hex_ext = {{(DIGW - VALUE_BITS){1'b0}}, req_number_value[VALUE_BITS-1:0]} << HEX_SHIFT;

   always_comb begin
      logic [3:0] nib;
      nib = 4'd0;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         nib = dig_ff[4*i +: 4];
         adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   always_comb begin
      val_in     = val_ff;
      dig_in     = dig_ff;
      bit_cnt_in = bit_cnt_ff;
      dcnt_in    = dcnt_ff;
      if (cmd.load) begin
         val_in     = req_number_value[VALUE_BITS-1:0];
         bit_cnt_in = BCW'(VALUE_BITS);
         if (mode_ff != '0) begin
            dig_in  = hex_ext;
            dcnt_in = DCW'(NIB);
         end else begin
            dig_in  = '0;
            dcnt_in = DCW'(DEC_DIGITS);
         end
      end else if (cmd.shift_bit) begin
         dig_in     = {adj[DIGW-2:0], val_ff[VALUE_BITS-1]};
         val_in     = val_ff << 1;
         bit_cnt_in = bit_cnt_ff - BCW'(1);
      end else if (cmd.skip || cmd.emit) begin
         dig_in  = dig_ff << 4;
         dcnt_in = dcnt_ff - DCW'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      dig_ff     <= dig_in;
      bit_cnt_ff <= bit_cnt_in;
      dcnt_ff    <= dcnt_in;
      if (cmd.load) begin
         hex_ff   <= (mode_ff != '0);
         upper_ff <= mode_ff[1];
      end
      if (cmd.emit) begin
         char_ff <= digit_code(top_nib, upper_ff);
         last_ff <= (dcnt_ff == DCW'(1));
      end
   end

   assign sts.hex       = hex_ff;
   assign sts.bits_done = (bit_cnt_ff == '0);
   assign sts.top_zero  = (top_nib == 4'd0);
   assign sts.one_left  = (dcnt_ff == DCW'(1));
   assign sts.out_free  = !valid_ff || rsp_ready;

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

// ===== rtl/rde_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks of the digit emitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_macros.svh"

module rde_checker
   import rde_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_digit_char,
   input logic              rsp_last_digit
);

   `RDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last_digit), "response changed while stalled")

   `RDE_ASSERT_NOW(a_char_legal, clock, reset, rsp_valid, (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) || (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd70) || (rsp_digit_char >= 7'd97 && rsp_digit_char <= 7'd102), "digit character out of range")

   `RDE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while one is in flight")

   `RDE_ASSERT_NOW(a_idle_last, clock, reset, req_ready && rsp_valid, rsp_last_digit, "idle with a non-final digit pending")

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the radix digit emitter. Numbers are fed from a
// queue through a valid/ready driver, and each accepted request is spelled
// out into its expected digits under the current radix mode. A monitor
// compares every response digit and its last flag in order. The run steps
// through all radix modes and several idling patterns, including a long
// receiver hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_top;
   import rde_pkg::*;

   typedef enum logic [MODE_W-1:0] {
      RADIX_DEC       = 2'd0,
      RADIX_HEX_LOWER = 2'd1,
      RADIX_HEX_UPPER = 2'd2,
      RADIX_HEX_SPARE = 2'd3
   } radix_mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_entry_type;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int SETTLE_CYCLES = 100;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [MODE_W-1:0]   csr_write_data   = '0;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [NUMBER_W-1:0] req_number_value = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [CHAR_W-1:0]   rsp_digit_char;
   logic                rsp_last_digit;

   logic [NUMBER_W-1:0] number_feed[$];
   digit_entry_type     expected_digits[$];
   radix_mode_type      active_mode    = RADIX_DEC;
   int                  tx_idle_pct    = 0;
   int                  rx_idle_pct    = 0;
   int                  error_count    = 0;
   int                  quiet_cycles   = 0;
   int                  hold_cycles    = 0;
   logic                req_taken      = 1'b0;
   logic                pressure_armed = 1'b0;
   logic                pressure_done  = 1'b0;

   radix_digit_emitter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_char   (rsp_digit_char),
      .rsp_last_digit   (rsp_last_digit)
   );

   always #5 clock = ~clock;

   // digits of one number, most significant first, appended to the expected list
   function automatic void spell_number(input logic [NUMBER_W-1:0] value,
                                        input radix_mode_type mode);
      logic [63:0]     rest;
      logic [63:0]     radix;
      logic [3:0]      d;
      digit_entry_type spelled[$];
      digit_entry_type entry;
      rest  = {1'b0, value};
      radix = (mode != RADIX_DEC) ? 64'd16 : 64'd10;
      entry.last_digit = 1'b1;
      do begin
         d = 4'(rest % radix);
         if (d < DIGIT_TEN) begin
            entry.digit_char = CHAR_ZERO + {3'b000, d};
         end else if (mode[1]) begin
            entry.digit_char = CHAR_UPPER_A + {3'b000, d - DIGIT_TEN};
         end else begin
            entry.digit_char = CHAR_LOWER_A + {3'b000, d - DIGIT_TEN};
         end
         spelled.push_front(entry);
         entry.last_digit = 1'b0;
         rest = rest / radix;
      end while (rest != 0);
      foreach (spelled[i]) expected_digits.push_back(spelled[i]);
   endfunction

   function automatic logic [NUMBER_W-1:0] pick_number();
      logic [63:0] raw;
      logic [63:0] edge_val;
      int          span;
      raw = {$urandom, $urandom};
      case ($urandom_range(4))
         0: begin
            return raw[NUMBER_W-1:0];
         end
         1: begin
            span = $urandom_range(1, NUMBER_W);
            return raw[NUMBER_W-1:0] >> (NUMBER_W - span);
         end
         2: begin
            edge_val = 64'd1;
            repeat ($urandom_range(18)) edge_val = edge_val * 64'd10;
            return NUMBER_W'(edge_val + $urandom_range(2) - 1);
         end
         3: begin
            edge_val = 64'd1 << (4 * $urandom_range(15));
            return NUMBER_W'(edge_val + $urandom_range(2) - 1);
         end
         default: begin
            return NUMBER_W'($urandom_range(300));
         end
      endcase
   endfunction

   task automatic log_failure(input string what);
      if (error_count < 10) $display("ERROR: %s", what);
      error_count++;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (number_feed.size() != 0 || req_valid || expected_digits.size() != 0);
   endtask

   task automatic next_phase(input radix_mode_type mode, input int tx_pct, input int rx_pct);
      wait_drained();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_mode = mode;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
   endtask

   task automatic queue_random(input int count);
      repeat (count) number_feed.push_back(pick_number());
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (number_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            req_valid        <= 1'b1;
            req_number_value <= number_feed.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with one long hold-off when armed
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (pressure_armed && !pressure_done && rsp_valid) begin
         rsp_ready     <= 1'b0;
         hold_cycles   <= HOLD_OFF_LEN;
         pressure_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      digit_entry_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               log_failure($sformatf("unexpected digit char=%0d last=%0b",
                                     rsp_digit_char, rsp_last_digit));
            end else begin
               want = expected_digits.pop_front();
               if (rsp_digit_char !== want.digit_char ||
                   rsp_last_digit !== want.last_digit) begin
                  log_failure($sformatf("digit mismatch exp char=%0d last=%0b got char=%0d last=%0b",
                                        want.digit_char, want.last_digit,
                                        rsp_digit_char, rsp_last_digit));
               end
            end
         end
         if (req_valid && req_ready) spell_number(req_number_value, active_mode);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      tx_idle_pct = 35;
      rx_idle_pct = 60;

      number_feed.push_back(63'd0);
      number_feed.push_back(63'd1);
      number_feed.push_back(63'd9);
      number_feed.push_back(63'd10);
      number_feed.push_back(63'd99);
      number_feed.push_back(63'd100);
      number_feed.push_back({NUMBER_W{1'b1}});
      number_feed.push_back(63'd999999999999999999);
      number_feed.push_back(63'd1000000000000000000);
      number_feed.push_back(63'h2AAA_AAAA_AAAA_AAAA);

      next_phase(RADIX_HEX_LOWER, 35, 60);
      number_feed.push_back(63'd0);
      number_feed.push_back(63'd10);
      number_feed.push_back(63'd15);
      number_feed.push_back(63'd16);
      number_feed.push_back(63'h0123_4567_89AB_CDEF);
      number_feed.push_back({NUMBER_W{1'b1}});

      next_phase(RADIX_HEX_UPPER, 35, 60);
      number_feed.push_back(63'd0);
      number_feed.push_back(63'd1);
      number_feed.push_back(63'd255);
      number_feed.push_back(63'h7EDC_BA98_7654_3210);
      number_feed.push_back(63'h4000_0000_0000_0000);

      next_phase(RADIX_HEX_SPARE, 35, 60);
      number_feed.push_back(63'd0);
      number_feed.push_back(63'hFA);
      number_feed.push_back({NUMBER_W{1'b1}});
      number_feed.push_back(63'h5555_5555_5555_5555);

      next_phase(RADIX_DEC, 35, 60);
      queue_random(70);
      next_phase(RADIX_HEX_LOWER, 35, 60);
      queue_random(50);
      next_phase(RADIX_HEX_UPPER, 60, 35);
      queue_random(60);
      next_phase(RADIX_DEC, 60, 35);
      queue_random(50);
      next_phase(RADIX_HEX_SPARE, 0, 0);
      queue_random(40);
      next_phase(RADIX_HEX_LOWER, 0, 0);
      pressure_armed = 1'b1;
      queue_random(40);
      next_phase(RADIX_HEX_UPPER, 0, 0);
      queue_random(40);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_ctrl.sv
rtl/rde_datapath.sv
rtl/radix_digit_emitter.sv
rtl/rde_checker.sv
bench/tb_top.sv
